// ===== rtl/rdc_pkg.sv =====
// Shared constants, word types, state codes and the digit-to-character map.
package rdc_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int MAX_BASE    = 36;
   localparam int BASE_WIDTH  = 6;
   localparam int CHAR_WIDTH  = 7;
   localparam int DIGIT_WIDTH = 6;
   localparam int STACK_DEPTH = VALUE_WIDTH;
   localparam int COUNT_WIDTH = $clog2(STACK_DEPTH + 1);
   localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);

   localparam logic [BASE_WIDTH-1:0]  MIN_BASE_CODE  = BASE_WIDTH'(2);
   localparam logic [BASE_WIDTH-1:0]  MAX_BASE_CODE  = BASE_WIDTH'(MAX_BASE);
   localparam logic [DIGIT_WIDTH-1:0] DECIMAL_DIGITS = DIGIT_WIDTH'(10);
   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO      = CHAR_WIDTH'(48);
   localparam logic [CHAR_WIDTH-1:0]  CHAR_LETTER    = CHAR_WIDTH'(55);

   typedef logic [DIGIT_WIDTH-1:0] digit_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [BASE_WIDTH-1:0]  base;
   } req_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] digit_char;
      logic                  last;
      logic                  empty_res;
   } rsp_type;

   typedef struct packed {
      logic done;
      logic zero;
   } div_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_to_char(input digit_type d);
      logic [CHAR_WIDTH-1:0] wide;
      wide = {1'b0, d};
      if (d < DECIMAL_DIGITS) begin
         return CHAR_ZERO + wide;
      end
      return CHAR_LETTER + wide;
   endfunction

endpackage

// ===== rtl/radix_digit_converter.sv =====
// Top level: converts a binary word into ASCII digits of a chosen base.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+----------------------------------
//  request  | start, busy, req_data         | taken when start high, busy low
//  response | rsp_valid, rsp_data           | one-cycle strobe, never held off
//
// Invalid base: one empty word on the cycle after acceptance; busy stays low.
// Otherwise the bit-serial divider produces the digits one by one onto the stack,
// then the digits leave one per cycle, with busy high until the last is issued.
// A single divider is shared by all digits.
// Reset is synchronous and clears the sequencer, divider control and stack count.
// The receiver cannot stall; every word is shown for exactly one cycle.
module radix_digit_converter (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rdc_pkg::req_type req_data,
   output logic             rsp_valid,
   output rdc_pkg::rsp_type rsp_data
);
   import rdc_pkg::*;

   state_type state_ff, state_in;
   logic [BASE_WIDTH-1:0] base_ff, base_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                   accept;
   logic                   base_ok;
   logic                   div_load;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [BASE_WIDTH-1:0]  div_base;
   logic [VALUE_WIDTH-1:0] div_quotient;
   digit_type              div_remainder;
   div_status_type         div_status;
   logic                   push;
   logic                   pop;
   digit_type              top_digit;
   count_type              stack_count;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign base_ok = (req_data.base >= MIN_BASE_CODE) && (req_data.base <= MAX_BASE_CODE);

   rdc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .load      (div_load),
      .dividend  (div_dividend),
      .divisor   (div_base),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   rdc_digit_stack u_stack (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .push_digit (div_remainder),
      .top_digit  (top_digit),
      .count      (stack_count)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && base_ok) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done && div_status.zero) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stack_count == COUNT_WIDTH'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      div_load     = 1'b0;
      div_dividend = div_quotient;
      div_base     = base_ff;
      base_in      = base_ff;
      push         = 1'b0;
      pop          = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      case (state_ff)
         ST_IDLE: begin
            div_dividend = req_data.value;
            div_base     = req_data.base;
            if (accept) begin
               base_in = req_data.base;
               if (base_ok) begin
                  div_load = 1'b1;
               end else begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.last      = 1'b1;
                  rsp_in.empty_res = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               push     = 1'b1;
               div_load = !div_status.zero;
            end
         end
         ST_EMIT: begin
            pop               = 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_in.digit_char = digit_to_char(top_digit);
            rsp_in.last       = (stack_count == COUNT_WIDTH'(1));
         end
         default: begin
            div_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff <= base_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_digits_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |=> rsp_valid)
      else $error("digit word sequence broken before last");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.empty_res) |-> (rsp_data.last && rsp_data.digit_char == '0))
      else $error("empty word not marked last or carries a character");

   a_quiet_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> !rsp_valid)
      else $error("word emitted during division");

   a_stack_not_empty_on_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (stack_count != '0))
      else $error("stack drained while emitting");

endmodule

// ===== rtl/rdc_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module rdc_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [rdc_pkg::VALUE_WIDTH-1:0] dividend,
   input  logic [rdc_pkg::BASE_WIDTH-1:0]  divisor,
   output logic [rdc_pkg::VALUE_WIDTH-1:0] quotient,
   output rdc_pkg::digit_type              remainder,
   output rdc_pkg::div_status_type         status
);
   import rdc_pkg::*;

   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   digit_type              rem_ff, rem_in;
   logic [BASE_WIDTH-1:0]  base_ff, base_in;
   logic [STEP_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [DIGIT_WIDTH:0]   rem_shift;
   logic [DIGIT_WIDTH:0]   rem_diff;
   logic                   fits;

   assign rem_shift = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, base_ff};
   assign fits      = rem_shift >= {1'b0, base_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      base_in = base_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (load) begin
         quot_in = dividend;
         rem_in  = '0;
         base_in = divisor;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         quot_in = {quot_ff[VALUE_WIDTH-2:0], fits};
         rem_in  = fits ? rem_diff[DIGIT_WIDTH-1:0] : rem_shift[DIGIT_WIDTH-1:0];
         cnt_in  = cnt_ff + STEP_WIDTH'(1);
         if (cnt_ff == STEP_WIDTH'(VALUE_WIDTH - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      base_ff <= base_in;
   end

   assign quotient    = quot_ff;
   assign remainder   = rem_ff;
   assign status.done = done_ff;
   assign status.zero = ~|quot_ff;

endmodule

// ===== rtl/rdc_digit_stack.sv =====
// Shift-register stack that reverses the digit order.
module rdc_digit_stack (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic                pop,
   input  rdc_pkg::digit_type  push_digit,
   output rdc_pkg::digit_type  top_digit,
   output rdc_pkg::count_type  count
);
   import rdc_pkg::*;

   digit_type stack_ff [STACK_DEPTH];
   digit_type stack_in [STACK_DEPTH];
   count_type count_ff, count_in;

   always_comb begin
      stack_in = stack_ff;
      count_in = count_ff;
      if (push) begin
         stack_in[0] = push_digit;
         for (int i = 1; i < STACK_DEPTH; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (pop) begin
         for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
         stack_in[STACK_DEPTH-1] = '0;
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      stack_ff <= stack_in;
   end

   assign top_digit = stack_ff[0];
   assign count     = count_ff;

endmodule
